// ===== rtl/wse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wse_pkg: shared types and codes for the WAV stream sample extractor
// Word layouts of both channels, the front-to-back queue item and event codes.
// ----------------------------------------------------------------------------
package wse_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [2:0] EV_SAMPLE        = 3'd0;
  localparam logic [2:0] EV_DATA_FOUND    = 3'd1;
  localparam logic [2:0] EV_BAD_SIGNATURE = 3'd2;
  localparam logic [2:0] EV_NO_DATA       = 3'd3;
  localparam logic [2:0] EV_BAD_WIDTH     = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } byte_word_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic signed [31:0] sample_value;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [15:0]        sample_width;
    logic [31:0]        sample_total;
  } event_word_t;

  // One classified event on its way from the parser to the back end.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [15:0] width;
    logic [31:0] length;
  } wse_item_t;

endpackage
`default_nettype wire

// ===== rtl/wav_stream_sample_extractor_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wav_stream_sample_extractor_core: WAV byte stream to Q1.31 PCM samples
// Parses a RIFF/WAVE file byte by byte and emits format, sample and error
// events.
// ----------------------------------------------------------------------------
//  channel   handshake                 word            direction
//  byte      byte_valid / byte_stall   byte_word_t     into the core
//  event     event_valid / event_stall event_word_t    out of the core
//
//  Rate: one byte per cycle while the queue is not full; an event is
//  registered in a queue slot and then in the event register before it appears.
//  Each data chunk header with a nonzero divisor holds the back end in a
//  divide: the sample count is divided out one quotient bit per cycle. The
//  queue absorbs QUEUE_DEPTH events meanwhile, then byte_stall rises until the back end pops again.
//  Reset: synchronous, active high; the parser then expects the RIFF tag.
//  Stalls: event_stall holds the event register and backs up the queue;
//  byte_stall is high only while the queue is full.
// ----------------------------------------------------------------------------
module wav_stream_sample_extractor_core
  import wse_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  byte_word_t  byte_word,
  output logic        event_valid,
  input  logic        event_stall,
  output event_word_t event_word
);

  // Parser to queue.
  logic      push;
  wse_item_t push_item;
  logic      queue_full;

  // Queue to back end.
  wse_item_t head;
  logic      queue_empty;
  logic      pop;

  // Front: accept one byte per cycle unless the queue is full; classify it.
  wse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  // Queue: decouple parsing from the divide and from output stalls.
  wse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  // Back: attach the sample count and hold the event until it is taken.
  wse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .queue_empty (queue_empty),
    .pop         (pop),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_word  (event_word)
  );

endmodule
`default_nettype wire

// ===== rtl/wse_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wse_front: RIFF/WAVE byte parser
// Walks tags, chunk headers and the fmt body one byte per cycle while the
// queue has room; assembles PCM samples and pushes classified events.
// ----------------------------------------------------------------------------
module wse_front
  import wse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_word_t byte_word,
  output logic       push,
  output wse_item_t  push_item,
  input  logic       queue_full
);

  localparam logic [31:0] TAG_RIFF     = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE     = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT      = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA     = 32'h6461_7461;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;

  typedef enum logic [8:0] {
    PH_RIFF    = 9'b0_0000_0001,
    PH_RSIZE   = 9'b0_0000_0010,
    PH_WAVE    = 9'b0_0000_0100,
    PH_CID     = 9'b0_0000_1000,
    PH_CSIZE   = 9'b0_0001_0000,
    PH_FMT     = 9'b0_0010_0000,
    PH_SKIP    = 9'b0_0100_0000,
    PH_SAMPLES = 9'b0_1000_0000,
    PH_IDLE    = 9'b1_0000_0000
  } phase_t;

  phase_t      phase, phase_next, cur_phase;
  logic [3:0]  field_byte_index, field_byte_index_next, cur_idx;
  logic [31:0] tag_shift, tag_shift_next, cur_tag;
  logic [31:0] chunk_length, chunk_length_next, cur_length;
  logic [31:0] skip_remaining, skip_remaining_next, cur_rem;
  logic [31:0] assembly_word, assembly_word_next, cur_asm;
  logic [15:0] kept_channels, kept_channels_next, cur_channels;
  logic [31:0] kept_rate, kept_rate_next, cur_rate;
  logic [15:0] kept_width, kept_width_next, cur_width;

  logic        accept;
  logic        emit;
  logic [2:0]  emit_kind;
  logic [31:0] emit_value;
  logic [31:0] emit_length;

  function automatic logic [31:0] to_q31(input logic [31:0] w, input logic [15:0] width);
    logic [31:0] q;
    q = w;
    if (width == 16'd8) begin
      q = {~w[7], w[6:0], 24'd0};
    end else if (width == 16'd16) begin
      q = {w[15:0], 16'd0};
    end else if (width == 16'd24) begin
      q = {w[23:0], 8'd0};
    end
    return q;
  endfunction

  assign accept     = byte_valid && !queue_full;
  assign byte_stall = queue_full;

  // A first byte restarts the parser before the byte itself is parsed.
  assign cur_phase    = byte_word.first_byte ? PH_RIFF : phase;
  assign cur_idx      = byte_word.first_byte ? 4'd0    : field_byte_index;
  assign cur_tag      = byte_word.first_byte ? 32'd0   : tag_shift;
  assign cur_length   = byte_word.first_byte ? 32'd0   : chunk_length;
  assign cur_rem      = byte_word.first_byte ? 32'd0   : skip_remaining;
  assign cur_asm      = byte_word.first_byte ? 32'd0   : assembly_word;
  assign cur_channels = byte_word.first_byte ? 16'd0   : kept_channels;
  assign cur_rate     = byte_word.first_byte ? 32'd0   : kept_rate;
  assign cur_width    = byte_word.first_byte ? 16'd0   : kept_width;

  always_comb begin
    logic [31:0] tag_acc;
    logic [31:0] len_acc;
    logic [31:0] asm_acc;
    logic [31:0] rem_dec;
    logic [31:0] fmt_skip;
    logic [3:0]  idx_inc;
    logic [2:0]  bps;
    logic        width_ok;

    tag_acc = {cur_tag[23:0], byte_word.data_byte};
    len_acc = cur_length;
    len_acc[8*cur_idx[1:0] +: 8] = byte_word.data_byte;
    asm_acc = cur_asm;
    asm_acc[8*cur_idx[1:0] +: 8] = byte_word.data_byte;
    rem_dec  = cur_rem - 32'd1;
    fmt_skip = (cur_length > FMT_BODY_LEN) ? (cur_length - FMT_BODY_LEN) : 32'd0;
    idx_inc  = cur_idx + 4'd1;
    bps      = cur_width[5:3];
    width_ok = (cur_width == 16'd8) || (cur_width == 16'd16) ||
               (cur_width == 16'd24) || (cur_width == 16'd32);

    phase_next            = cur_phase;
    field_byte_index_next = cur_idx;
    tag_shift_next        = cur_tag;
    chunk_length_next     = cur_length;
    skip_remaining_next   = cur_rem;
    assembly_word_next    = cur_asm;
    kept_channels_next    = cur_channels;
    kept_rate_next        = cur_rate;
    kept_width_next       = cur_width;
    emit        = 1'b0;
    emit_kind   = EV_SAMPLE;
    emit_value  = 32'd0;
    emit_length = 32'd0;

    unique case (cur_phase)
      PH_RIFF, PH_WAVE: begin
        tag_shift_next        = tag_acc;
        field_byte_index_next = idx_inc;
        if (cur_idx == 4'd3) begin
          field_byte_index_next = 4'd0;
          if (tag_acc != ((cur_phase == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
            emit       = 1'b1;
            emit_kind  = EV_BAD_SIGNATURE;
            phase_next = PH_IDLE;
          end else begin
            phase_next = (cur_phase == PH_RIFF) ? PH_RSIZE : PH_CID;
          end
        end
      end
      PH_RSIZE: begin
        field_byte_index_next = idx_inc;
        if (cur_idx == 4'd3) begin
          field_byte_index_next = 4'd0;
          phase_next            = PH_WAVE;
        end
      end
      PH_CID: begin
        tag_shift_next        = tag_acc;
        field_byte_index_next = idx_inc;
        if (cur_idx == 4'd3) begin
          field_byte_index_next = 4'd0;
          chunk_length_next     = 32'd0;
          phase_next            = PH_CSIZE;
        end
      end
      PH_CSIZE: begin
        chunk_length_next     = len_acc;
        field_byte_index_next = idx_inc;
        if (cur_idx == 4'd3) begin
          field_byte_index_next = 4'd0;
          if (cur_tag == TAG_FMT) begin
            phase_next = PH_FMT;
          end else if (cur_tag == TAG_DATA) begin
            emit        = 1'b1;
            emit_length = len_acc;
            phase_next  = PH_IDLE;
            if (width_ok) begin
              // Count down data bytes; a sample needs bps of them.
              emit_kind           = EV_DATA_FOUND;
              skip_remaining_next = len_acc;
              assembly_word_next  = 32'd0;
              if (len_acc >= {29'd0, bps}) begin
                phase_next = PH_SAMPLES;
              end
            end else begin
              emit_kind = EV_BAD_WIDTH;
            end
          end else begin
            skip_remaining_next = len_acc;
            phase_next          = (len_acc != 32'd0) ? PH_SKIP : PH_CID;
          end
        end
      end
      PH_FMT: begin
        unique case (cur_idx)
          4'd2:    kept_channels_next       = {8'd0, byte_word.data_byte};
          4'd3:    kept_channels_next[15:8] = byte_word.data_byte;
          4'd4:    kept_rate_next           = {24'd0, byte_word.data_byte};
          4'd5:    kept_rate_next[15:8]     = byte_word.data_byte;
          4'd6:    kept_rate_next[23:16]    = byte_word.data_byte;
          4'd7:    kept_rate_next[31:24]    = byte_word.data_byte;
          4'd14:   kept_width_next          = {8'd0, byte_word.data_byte};
          4'd15:   kept_width_next[15:8]    = byte_word.data_byte;
          default: kept_width_next          = cur_width;
        endcase
        field_byte_index_next = idx_inc;
        if (cur_idx == 4'd15) begin
          field_byte_index_next = 4'd0;
          skip_remaining_next   = fmt_skip;
          phase_next            = (fmt_skip != 32'd0) ? PH_SKIP : PH_CID;
        end
      end
      PH_SKIP: begin
        skip_remaining_next = (cur_rem != 32'd0) ? rem_dec : cur_rem;
        if (skip_remaining_next == 32'd0) begin
          phase_next = PH_CID;
        end
      end
      PH_SAMPLES: begin
        skip_remaining_next = rem_dec;
        if (idx_inc[2:0] == bps) begin
          emit                  = 1'b1;
          emit_kind             = EV_SAMPLE;
          emit_value            = to_q31(asm_acc, cur_width);
          emit_length           = cur_length;
          field_byte_index_next = 4'd0;
          assembly_word_next    = 32'd0;
          if (rem_dec < {29'd0, bps}) begin
            phase_next = PH_IDLE;
          end
        end else begin
          field_byte_index_next = idx_inc;
          assembly_word_next    = asm_acc;
        end
      end
      default: begin
        phase_next = cur_phase;
      end
    endcase

    // End of file before the data header completed.
    if (byte_word.final_byte) begin
      if (!emit && (phase_next == PH_RIFF || phase_next == PH_RSIZE ||
                    phase_next == PH_WAVE || phase_next == PH_CID ||
                    phase_next == PH_CSIZE || phase_next == PH_FMT ||
                    phase_next == PH_SKIP)) begin
        emit        = 1'b1;
        emit_kind   = EV_NO_DATA;
        emit_value  = 32'd0;
        emit_length = 32'd0;
      end
      phase_next = PH_IDLE;
    end
  end

  assign push               = accept && emit;
  assign push_item.kind     = emit_kind;
  assign push_item.value    = emit_value;
  assign push_item.channels = kept_channels_next;
  assign push_item.rate     = kept_rate_next;
  assign push_item.width    = kept_width_next;
  assign push_item.length   = emit_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_RIFF;
      field_byte_index <= 4'd0;
      tag_shift        <= 32'd0;
      chunk_length     <= 32'd0;
      skip_remaining   <= 32'd0;
      assembly_word    <= 32'd0;
      kept_channels    <= 16'd0;
      kept_rate        <= 32'd0;
      kept_width       <= 16'd0;
    end else if (accept) begin
      phase            <= phase_next;
      field_byte_index <= field_byte_index_next;
      tag_shift        <= tag_shift_next;
      chunk_length     <= chunk_length_next;
      skip_remaining   <= skip_remaining_next;
      assembly_word    <= assembly_word_next;
      kept_channels    <= kept_channels_next;
      kept_rate        <= kept_rate_next;
      kept_width       <= kept_width_next;
    end
  end

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_remaining != 32'd0)
    else $error("skip phase with no bytes left");

  a_samples_cover: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SAMPLES |->
      ({1'b0, skip_remaining} + {29'd0, field_byte_index}) >= {30'd0, kept_width[5:3]})
    else $error("sample phase without a full sample left");

endmodule
`default_nettype wire

// ===== rtl/wse_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wse_queue: event queue between parser and back end
// Small register FIFO; lets the parser run while the back end divides.
// ----------------------------------------------------------------------------
module wse_queue
  import wse_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  wse_item_t push_item,
  input  logic      pop,
  output wse_item_t head,
  output logic      full,
  output logic      empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  wse_item_t      slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == CntW'($past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire

// ===== rtl/wse_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wse_back: event back end
// Computes the sample count with a bit-serial divider and drives the
// registered event channel.
// ----------------------------------------------------------------------------
module wse_back
  import wse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  wse_item_t   head,
  input  logic        queue_empty,
  output logic        pop,
  output logic        event_valid,
  input  logic        event_stall,
  output event_word_t event_word
);

  typedef enum logic [2:0] {
    BK_RUN = 3'b001,
    BK_DIV = 3'b010,
    BK_FIN = 3'b100
  } back_state_t;

  back_state_t state, state_next;
  wse_item_t   hold;
  logic [31:0] quot;
  logic [12:0] rem;
  logic [4:0]  step;
  logic [31:0] total_held;

  logic        out_free;
  logic        head_div;
  logic [12:0] head_divisor;
  logic        start;
  logic        load;
  event_word_t load_word;
  logic [13:0] trial;
  logic        trial_ge;
  logic [12:0] rem_next;
  logic [31:0] quot_next;

  assign out_free     = !event_valid || !event_stall;
  assign head_div     = (head.kind == EV_DATA_FOUND) || (head.kind == EV_BAD_WIDTH);
  assign head_divisor = head.width[15:3];

  // One quotient bit per cycle.
  assign trial     = {rem, quot[31]};
  assign trial_ge  = trial >= {1'b0, hold.width[15:3]};
  assign rem_next  = trial_ge ? 13'(trial - {1'b0, hold.width[15:3]}) : trial[12:0];
  assign quot_next = {quot[30:0], trial_ge};

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    start      = 1'b0;
    load       = 1'b0;
    load_word  = '0;
    unique case (state)
      BK_RUN: begin
        if (!queue_empty) begin
          if (head_div && head_divisor != 13'd0) begin
            pop        = 1'b1;
            start      = 1'b1;
            state_next = BK_DIV;
          end else if (out_free) begin
            pop                     = 1'b1;
            load                    = 1'b1;
            load_word.event_kind    = head.kind;
            load_word.sample_value  = $signed(head.value);
            load_word.channel_count = head.channels;
            load_word.sample_rate   = head.rate;
            load_word.sample_width  = head.width;
            load_word.sample_total  = (head.kind == EV_SAMPLE) ? total_held : 32'd0;
          end
        end
      end
      BK_DIV: begin
        if (step == 5'd31) begin
          state_next = BK_FIN;
        end
      end
      BK_FIN: begin
        if (out_free) begin
          load                    = 1'b1;
          load_word.event_kind    = hold.kind;
          load_word.sample_value  = $signed(hold.value);
          load_word.channel_count = hold.channels;
          load_word.sample_rate   = hold.rate;
          load_word.sample_width  = hold.width;
          load_word.sample_total  = total_held;
          state_next              = BK_RUN;
        end
      end
      default: begin
        state_next = BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hold <= head;
      quot <= head.length;
      rem  <= 13'd0;
    end else if (state == BK_DIV) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_RUN;
      step        <= 5'd0;
      total_held  <= 32'd0;
      event_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        step <= 5'd0;
      end else if (state == BK_DIV) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          total_held <= quot_next;
        end
      end
      // Zero divisor: the count is zero.
      if (state == BK_RUN && pop && !start && head_div) begin
        total_held <= 32'd0;
      end
      if (load) begin
        event_valid <= 1'b1;
      end else if (!event_stall) begin
        event_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_word <= load_word;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !queue_empty)
    else $error("pop from empty queue");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == BK_DIV |-> hold.width[15:3] != 13'd0)
    else $error("divide with zero divisor");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    event_valid && (event_word.event_kind == EV_BAD_SIGNATURE ||
                    event_word.event_kind == EV_NO_DATA)
      |-> event_word.sample_total == 32'd0 && event_word.sample_value == 32'sd0)
    else $error("error event carries a nonzero value or count");

endmodule
`default_nettype wire

// ===== bench/wav_stream_event_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_stream_event_checker: expected-event predictor and comparator
// Tracks every accepted byte word with its own copy of the RIFF/WAVE parser
// and matches each accepted event word, in order, against the expected one.
// ----------------------------------------------------------------------------
module wav_stream_event_checker
  import wse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  byte_word_t  byte_word,
  input  logic        event_valid,
  input  logic        event_stall,
  input  event_word_t event_word,
  output int          mismatch_count,
  output int          events_pending
);

  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FMT  = "fmt ";
  localparam logic [31:0] TAG_DATA = "data";
  localparam logic [4:0]  FMT_BODY_BYTES = 5'd16;

  typedef enum logic [3:0] {
    ST_RIFF_TAG,
    ST_RIFF_SIZE,
    ST_WAVE_TAG,
    ST_CHUNK_ID,
    ST_CHUNK_SIZE,
    ST_FMT_BODY,
    ST_SKIP,
    ST_SAMPLES,
    ST_IDLE
  } parse_state_e;

  parse_state_e phase;
  logic [4:0]   byte_idx;
  logic [31:0]  tag_reg;
  logic [31:0]  chunk_len;
  logic [31:0]  skip_left;
  logic [31:0]  sample_acc;
  logic [15:0]  fmt_channels;
  logic [31:0]  fmt_rate;
  logic [15:0]  fmt_width;
  logic [31:0]  samples_remaining;

  event_word_t  expected_events[$];
  int           event_seq;

  task automatic reset_parser();
    phase             = ST_RIFF_TAG;
    byte_idx          = '0;
    tag_reg           = '0;
    chunk_len         = '0;
    skip_left         = '0;
    sample_acc        = '0;
    fmt_channels      = '0;
    fmt_rate          = '0;
    fmt_width         = '0;
    samples_remaining = '0;
  endtask

  function automatic logic [31:0] sample_count();
    logic [15:0] bytes_per;
    bytes_per = fmt_width >> 3;
    return (bytes_per != 16'd0) ? chunk_len / bytes_per : 32'd0;
  endfunction

  function automatic event_word_t make_event(input logic [2:0]  kind,
                                             input logic [31:0] value,
                                             input logic [31:0] total);
    event_word_t e;
    e.event_kind    = kind;
    e.sample_value  = value;
    e.channel_count = fmt_channels;
    e.sample_rate   = fmt_rate;
    e.sample_width  = fmt_width;
    e.sample_total  = total;
    return e;
  endfunction

  task automatic enter_skip(input logic [31:0] len);
    skip_left = len;
    phase     = (len != 32'd0) ? ST_SKIP : ST_CHUNK_ID;
  endtask

  // Advance the parser by one byte; queue the event it gives, if any.
  task automatic parse_wav_byte(input byte_word_t w);
    event_word_t ev;
    logic        fired;
    logic [31:0] total;
    logic [15:0] bytes_per;
    logic [31:0] sample;
    fired = 1'b0;
    ev    = '0;
    if (w.first_byte) reset_parser();
    case (phase)
      ST_RIFF_TAG, ST_WAVE_TAG: begin
        tag_reg  = {tag_reg[23:0], w.data_byte};
        byte_idx = byte_idx + 5'd1;
        if (byte_idx >= 5'd4) begin
          byte_idx = '0;
          if (tag_reg != ((phase == ST_RIFF_TAG) ? TAG_RIFF : TAG_WAVE)) begin
            ev    = make_event(EV_BAD_SIGNATURE, 32'd0, 32'd0);
            fired = 1'b1;
            phase = ST_IDLE;
          end else if (phase == ST_RIFF_TAG) begin
            phase = ST_RIFF_SIZE;
          end else begin
            phase = ST_CHUNK_ID;
          end
        end
      end
      ST_RIFF_SIZE: begin
        byte_idx = byte_idx + 5'd1;
        if (byte_idx >= 5'd4) begin
          byte_idx = '0;
          phase    = ST_WAVE_TAG;
        end
      end
      ST_CHUNK_ID: begin
        tag_reg  = {tag_reg[23:0], w.data_byte};
        byte_idx = byte_idx + 5'd1;
        if (byte_idx >= 5'd4) begin
          byte_idx  = '0;
          chunk_len = '0;
          phase     = ST_CHUNK_SIZE;
        end
      end
      ST_CHUNK_SIZE: begin
        chunk_len = chunk_len | (32'(w.data_byte) << (8 * byte_idx[1:0]));
        byte_idx  = byte_idx + 5'd1;
        if (byte_idx >= 5'd4) begin
          byte_idx = '0;
          if (tag_reg == TAG_FMT) begin
            phase = ST_FMT_BODY;
          end else if (tag_reg == TAG_DATA) begin
            total = sample_count();
            if (fmt_width == 16'd8 || fmt_width == 16'd16 ||
                fmt_width == 16'd24 || fmt_width == 16'd32) begin
              ev                = make_event(EV_DATA_FOUND, 32'd0, total);
              samples_remaining = total;
              sample_acc        = '0;
              phase             = (total != 32'd0) ? ST_SAMPLES : ST_IDLE;
            end else begin
              ev    = make_event(EV_BAD_WIDTH, 32'd0, total);
              phase = ST_IDLE;
            end
            fired = 1'b1;
          end else begin
            enter_skip(chunk_len);
          end
        end
      end
      ST_FMT_BODY: begin
        case (byte_idx)
          5'd2:  fmt_channels = {8'd0, w.data_byte};
          5'd3:  fmt_channels = fmt_channels | {w.data_byte, 8'd0};
          5'd4:  fmt_rate     = {24'd0, w.data_byte};
          5'd5:  fmt_rate     = fmt_rate | {16'd0, w.data_byte, 8'd0};
          5'd6:  fmt_rate     = fmt_rate | {8'd0, w.data_byte, 16'd0};
          5'd7:  fmt_rate     = fmt_rate | {w.data_byte, 24'd0};
          5'd14: fmt_width    = {8'd0, w.data_byte};
          5'd15: fmt_width    = fmt_width | {w.data_byte, 8'd0};
          default: ;
        endcase
        byte_idx = byte_idx + 5'd1;
        if (byte_idx >= FMT_BODY_BYTES) begin
          byte_idx = '0;
          enter_skip((chunk_len > 32'd16) ? chunk_len - 32'd16 : 32'd0);
        end
      end
      ST_SKIP: begin
        if (skip_left != 32'd0) skip_left = skip_left - 32'd1;
        if (skip_left == 32'd0) phase = ST_CHUNK_ID;
      end
      ST_SAMPLES: begin
        bytes_per = fmt_width >> 3;
        if (bytes_per == 16'd0 || bytes_per > 16'd4 || samples_remaining == 32'd0) begin
          phase = ST_IDLE;
        end else begin
          sample_acc = sample_acc | (32'(w.data_byte) << (8 * byte_idx[1:0]));
          byte_idx   = byte_idx + 5'd1;
          if (byte_idx >= bytes_per) begin
            // scale to Q1.31: 8-bit PCM is offset binary, wider is two's complement
            case (fmt_width)
              16'd8:   sample = {sample_acc[7:0] ^ 8'h80, 24'd0};
              16'd16:  sample = {sample_acc[15:0], 16'd0};
              16'd24:  sample = {sample_acc[23:0], 8'd0};
              default: sample = sample_acc;
            endcase
            ev                = make_event(EV_SAMPLE, sample, sample_count());
            fired             = 1'b1;
            byte_idx          = '0;
            sample_acc        = '0;
            samples_remaining = samples_remaining - 32'd1;
            if (samples_remaining == 32'd0) phase = ST_IDLE;
          end
        end
      end
      default: ;
    endcase

    // end of file before the data header completed
    if (w.final_byte) begin
      if (!fired && phase < ST_SAMPLES) begin
        ev    = make_event(EV_NO_DATA, 32'd0, 32'd0);
        fired = 1'b1;
      end
      phase = ST_IDLE;
    end
    if (fired) expected_events.push_back(ev);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] event %0d: %s", $time, event_seq, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    event_word_t want;
    string       diffs;
    if (rst) begin
      reset_parser();
      expected_events.delete();
      mismatch_count = 0;
      event_seq      = 0;
    end else begin
      // compare before predicting so that a premature event never matches
      if (event_valid && !event_stall) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected, kind %0d value %h",
                                    event_word.event_kind, event_word.sample_value));
        end else begin
          want  = expected_events.pop_front();
          diffs = "";
          if (event_word.event_kind !== want.event_kind)
            diffs = {diffs, $sformatf(" kind %0d/%0d", event_word.event_kind,
                                      want.event_kind)};
          if (event_word.sample_value !== want.sample_value)
            diffs = {diffs, $sformatf(" value %h/%h", event_word.sample_value,
                                      want.sample_value)};
          if (event_word.channel_count !== want.channel_count)
            diffs = {diffs, $sformatf(" channels %h/%h", event_word.channel_count,
                                      want.channel_count)};
          if (event_word.sample_rate !== want.sample_rate)
            diffs = {diffs, $sformatf(" rate %h/%h", event_word.sample_rate,
                                      want.sample_rate)};
          if (event_word.sample_width !== want.sample_width)
            diffs = {diffs, $sformatf(" width %h/%h", event_word.sample_width,
                                      want.sample_width)};
          if (event_word.sample_total !== want.sample_total)
            diffs = {diffs, $sformatf(" total %h/%h", event_word.sample_total,
                                      want.sample_total)};
          if (diffs != "") report_mismatch({"got/exp", diffs});
        end
        event_seq++;
      end
      if (byte_valid && !byte_stall) parse_wav_byte(byte_word);
    end
    events_pending = expected_events.size();
  end

endmodule

// ===== bench/wav_stream_sample_extractor_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_stream_sample_extractor_core_tb: byte-stream bench for the WAV extractor
// Feeds directed and random RIFF/WAVE files one byte word at a time, with
// random gaps and receiver stalls, and leaves prediction and comparison of
// the event words to the checker instantiated beside the core.
// ----------------------------------------------------------------------------
module wav_stream_sample_extractor_core_tb;
  import wse_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int QUIET_LIMIT   = 3000;  // cycles without any handshake
  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 40;    // trailing wait after the last event
  localparam int ITEM_BUDGET   = 550;   // byte words offered over the whole run
  localparam int IDLE_PERCENT  = 7;

  localparam logic [31:0] ID_RIFF = "RIFF";
  localparam logic [31:0] ID_WAVE = "WAVE";
  localparam logic [31:0] ID_FMT  = "fmt ";
  localparam logic [31:0] ID_DATA = "data";

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        byte_valid  = 1'b0;
  byte_word_t  byte_word   = '0;
  logic        event_stall = 1'b0;
  logic        byte_stall;
  logic        event_valid;
  event_word_t event_word;

  int          fail_total;
  int          events_pending;
  int          quiet_cycles  = 0;
  int          bytes_offered = 0;

  // calm: no random gaps or stalls on either side
  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;

  byte_word_t  file_q[$];

  always #(HALF_PERIOD) clk = ~clk;

  wav_stream_sample_extractor_core dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_word   (byte_word),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_word  (event_word)
  );

  wav_stream_event_checker ev_check (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .byte_word      (byte_word),
    .event_valid    (event_valid),
    .event_stall    (event_stall),
    .event_word     (event_word),
    .mismatch_count (fail_total),
    .events_pending (events_pending)
  );

  // --------------------------------------------------------------------------
  // File assembly: bytes build up in file_q, flags are set when it is sent.
  // --------------------------------------------------------------------------
  function automatic void put_raw(input logic [7:0] b);
    byte_word_t w;
    w           = '0;
    w.data_byte = b;
    file_q.push_back(w);
  endfunction

  // chunk ids go out in reading order, most significant character first
  function automatic void add_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) put_raw(t[8*i +: 8]);
  endfunction

  function automatic void add_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) put_raw(v[8*i +: 8]);
  endfunction

  // RIFF tag, a random RIFF size (ignored by the core), WAVE tag
  function automatic void add_wav_head();
    add_tag(ID_RIFF);
    add_le($urandom, 4);
    add_tag(ID_WAVE);
  endfunction

  // Always write the 16 canonical body bytes: the core consumes 16 even when
  // the size field says less. Pad with random bytes when it says more.
  function automatic void add_fmt(input logic [15:0] chans, input logic [31:0] rate,
                                  input logic [15:0] bits, input int body_len);
    add_tag(ID_FMT);
    add_le(body_len, 4);
    add_le(32'd1, 2);
    add_le(32'(chans), 2);
    add_le(rate, 4);
    add_le($urandom, 4);
    add_le($urandom, 2);
    add_le(32'(bits), 2);
    for (int i = 16; i < body_len; i++) put_raw(8'($urandom));
  endfunction

  function automatic void add_chunk(input logic [31:0] id, input int len);
    add_tag(id);
    add_le(len, 4);
    repeat (len) put_raw(8'($urandom));
  endfunction

  // --------------------------------------------------------------------------
  // Byte channel driver. Gaps are decided before a word is offered, so valid
  // never reacts to stall; an offered word is held until it is taken.
  // --------------------------------------------------------------------------
  task automatic put_byte(input byte_word_t w);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_word  <= w;
    do @(posedge clk); while (byte_stall);
    bytes_offered++;
  endtask

  task automatic send_file(input bit mark_first, input bit mark_final);
    byte_word_t w;
    if (file_q.size() != 0) begin
      w            = file_q[0];
      w.first_byte = mark_first;
      file_q[0]    = w;
      w            = file_q[file_q.size() - 1];
      w.final_byte = mark_final;
      file_q[file_q.size() - 1] = w;
      foreach (file_q[i]) put_byte(file_q[i]);
      file_q.delete();
    end
  endtask

  // Drop valid and hold until every predicted event has been taken.
  task automatic drain_events();
    byte_valid <= 1'b0;
    do @(posedge clk); while (events_pending != 0);
  endtask

  // --------------------------------------------------------------------------
  // Event channel receiver: random stalls, plus one long hold-off on request
  // so that the queue fills and byte_stall has to rise.
  // --------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        repeat (HOLD_CYCLES) begin
          event_stall <= 1'b1;
          @(posedge clk);
        end
      end
      event_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when neither channel moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (event_valid && !event_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] bits;
    logic [31:0] size;
    int          pick;
    int          shape;
    int          cut;
    int          idx;
    int          file_no;
    bit          mark_first;
    bit          mark_final;
    byte_word_t  w;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // 16-bit file straight after reset, without a first-byte mark: the parser
    // must already be waiting for the RIFF tag. Samples 0000, FFFF, 8000, 7FFF.
    add_wav_head();
    add_fmt(16'd2, 32'd44100, 16'd16, 16);
    add_tag(ID_DATA);
    add_le(32'd8, 4);
    add_le(32'hFFFF_0000, 4);
    add_le(32'h7FFF_8000, 4);
    send_file(1'b0, 1'b1);

    // no gaps and no stalls over the next three files
    calm = 1'b1;

    // 8-bit extremes behind an unknown chunk, a long fmt chunk and an empty
    // unknown chunk; samples 00, FF, 80, 7F
    add_wav_head();
    add_chunk("LIST", 3);
    add_fmt(16'd1, 32'd8000, 16'd8, 18);
    add_chunk("fact", 0);
    add_tag(ID_DATA);
    add_le(32'd4, 4);
    add_le(32'h7F80_FF00, 4);
    send_file(1'b1, 1'b1);

    // 24-bit, data size not a multiple of the sample: the odd byte and the
    // trailing bytes must be ignored
    add_wav_head();
    add_fmt(16'd1, 32'd96000, 16'd24, 16);
    add_tag(ID_DATA);
    add_le(32'd7, 4);
    add_le(32'h80_0000, 3);
    add_le(32'h7F_FFFF, 3);
    repeat (4) put_raw(8'($urandom));
    send_file(1'b1, 1'b1);

    // 32-bit extremes with all-ones channel count, rate and data size: huge
    // count, end of file in the middle of a sample
    add_wav_head();
    add_fmt(16'hFFFF, 32'hFFFF_FFFF, 16'd32, 16);
    add_tag(ID_DATA);
    add_le(32'hFFFF_FFFF, 4);
    add_le(32'h8000_0000, 4);
    add_le(32'h7FFF_FFFF, 4);
    add_le(32'h0000_0000, 4);
    add_le(32'hFFFF_FFFF, 4);
    add_le(32'h0000_A55A, 2);
    send_file(1'b1, 1'b1);

    calm = 1'b0;

    // bad RIFF tag; the bytes after it are ignored
    add_tag("RIFX");
    repeat (2) put_raw(8'($urandom));
    send_file(1'b1, 1'b1);

    // bad WAVE tag, left open: the next first-byte mark restarts the parser
    add_tag(ID_RIFF);
    add_le($urandom, 4);
    add_tag("WAVF");
    send_file(1'b1, 1'b0);

    // short fmt chunk that still consumes 16 bytes, width 12 unsupported
    add_wav_head();
    add_fmt(16'd1, 32'd22050, 16'd12, 4);
    add_tag(ID_DATA);
    add_le(32'd10, 4);
    send_file(1'b1, 1'b1);

    // data chunk with no fmt chunk at all: width 0 is unsupported
    add_wav_head();
    add_tag(ID_DATA);
    add_le(32'd20, 4);
    repeat (3) put_raw(8'($urandom));
    send_file(1'b1, 1'b0);

    // data shorter than one sample gives a zero count; the byte is ignored
    add_wav_head();
    add_fmt(16'd1, 32'd11025, 16'd16, 16);
    add_tag(ID_DATA);
    add_le(32'd1, 4);
    put_raw(8'hA5);
    send_file(1'b1, 1'b1);

    // end of file inside the RIFF size field
    add_tag(ID_RIFF);
    add_le($urandom, 2);
    send_file(1'b1, 1'b1);

    // end of file while skipping a large unknown chunk
    add_wav_head();
    add_tag("junk");
    add_le(32'd1000, 4);
    repeat (5) put_raw(8'($urandom));
    send_file(1'b1, 1'b1);

    // end of file on the byte that completes the data header: only the
    // data-found event may come out
    add_wav_head();
    add_fmt(16'd1, 32'd8000, 16'd8, 16);
    add_tag(ID_DATA);
    add_le(32'd3, 4);
    send_file(1'b1, 1'b1);

    // second fmt chunk cut off after nine body bytes: the no-data event
    // carries the new channel count and rate with the old width
    add_wav_head();
    add_fmt(16'd2, 32'd48000, 16'd16, 16);
    add_tag(ID_FMT);
    add_le(32'd16, 4);
    add_le(32'd1, 2);
    add_le(32'h1234, 2);
    add_le(32'hA5A5_5A5A, 4);
    put_raw(8'h11);
    send_file(1'b1, 1'b1);

    // restart in the middle of a sample stream
    add_wav_head();
    add_fmt(16'd1, 32'd16000, 16'd16, 16);
    add_tag(ID_DATA);
    add_le(32'd10, 4);
    repeat (3) put_raw(8'($urandom));
    send_file(1'b1, 1'b0);

    // first and final mark on one and the same byte
    put_raw(8'h52);
    send_file(1'b1, 1'b1);

    // Long receiver hold-off during a 20-sample 8-bit file: the sender keeps
    // offering, the event queue fills and the byte side must stall. Then
    // pause the sender until every event is out.
    hold_request = 1'b1;
    add_wav_head();
    add_fmt(16'd1, 32'd8000, 16'd8, 16);
    add_tag(ID_DATA);
    add_le(32'd20, 4);
    repeat (20) put_raw(8'($urandom));
    send_file(1'b1, 1'b1);
    drain_events();

    // Random files up to the byte budget: mostly well formed with random
    // content, some with a flipped header bit, some cut short, a few
    // without marks.
    file_no = 0;
    while (file_no == 0 || bytes_offered < ITEM_BUDGET) begin
      pick = $urandom_range(11);
      if (pick == 0)     bits = 16'($urandom);
      else if (pick < 3) bits = 16'd8;
      else if (pick < 6) bits = 16'd16;
      else if (pick < 9) bits = 16'd24;
      else               bits = 16'd32;

      add_wav_head();
      repeat ($urandom_range(2)) add_chunk($urandom, $urandom_range(5));
      if ($urandom_range(4) == 0) add_fmt(16'($urandom), $urandom, 16'd16, 16);
      add_fmt(16'($urandom), $urandom, bits,
              ($urandom_range(3) == 0) ? $urandom_range(10, 22) : 16);
      size = ($urandom_range(15) == 0) ? $urandom : $urandom_range(24);
      add_tag(ID_DATA);
      add_le(size, 4);
      repeat ((size > 32'd24) ? $urandom_range(1, 16) : size + $urandom_range(3))
        put_raw(8'($urandom));

      shape = $urandom_range(99);
      if (shape < 8) begin
        // flip one bit somewhere in the RIFF/WAVE header
        idx         = $urandom_range(11);
        w           = file_q[idx];
        w.data_byte = w.data_byte ^ (8'd1 << $urandom_range(7));
        file_q[idx] = w;
      end else if (shape < 20) begin
        cut = $urandom_range(1, file_q.size());
        while (file_q.size() > cut) void'(file_q.pop_back());
      end

      mark_first = ($urandom_range(19) != 0);
      mark_final = ($urandom_range(4) != 0);
      send_file(mark_first, mark_final);

      // stray bytes between files: ignored after a final byte, parsed otherwise
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4)) put_raw(8'($urandom));
        send_file(1'b0, 1'b0);
      end
      if ($urandom_range(9) < 2) drain_events();
      file_no++;
    end

    calm = 1'b0;
    drain_events();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_total == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
